FILE: hw/rtl/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] ContLo      = 8'h80;
  localparam logic [7:0] ContHi      = 8'hBF;
  localparam logic [7:0] ContLoE0    = 8'hA0;
  localparam logic [7:0] ContHiED    = 8'h9F;
  localparam logic [7:0] ContLoF0    = 8'h90;
  localparam logic [7:0] ContHiF4    = 8'h8F;
  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam logic [7:0] EndByte     = 8'h00;

  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_ERROR = 2'd1,
    ST_END   = 2'd2
  } status_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    status_t        st;
  } res_t;

  // one or two results caused by a single input byte
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } job_t;

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
// UTF-8 decoder, one byte per in_ transfer, results on out_ as 21-bit code
// points with a status kind (valid, malformed, end of string on byte 0). A
// byte is taken every cycle while the queue has room; the output carries one
// result per cycle while out_tready is high, so bytes that give two results
// (a failed continuation followed by its own decode, or a zero byte inside an
// open sequence) can outpace it; a four-entry queue between the decode and
// output stages absorbs them. Results pass the queue and a job register.
// cfg_data[0] selects U+FFFD (1, default) or zero (0) for error results.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import u8sd_pkg::*;

  logic replace_r;
  logic q_push, q_not_full, q_pop, q_not_empty;
  job_t q_in, q_out;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_r <= 1'b1;
    end else if (cfg_valid) begin
      replace_r <= cfg_data;
    end
  end

  u8sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .replace    (replace_r),
    .byte_valid (in_tvalid),
    .byte_in    (in_tdata),
    .q_ready    (q_not_full),
    .byte_ready (in_tready),
    .q_push     (q_push),
    .q_job      (q_in)
  );

  u8sd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_out)
  );

  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .res_last  (out_tlast)
  );

  assign out_tdata = {3'b000, res.cp};
  assign out_tuser = res.st;

endmodule

FILE: hw/rtl/u8sd_front.sv
module u8sd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              replace,
  input  logic              byte_valid,
  input  logic [7:0]        byte_in,
  input  logic              q_ready,
  output logic              byte_ready,
  output logic              q_push,
  output u8sd_pkg::job_t    q_job
);
  import u8sd_pkg::*;

  typedef struct packed {
    logic           emit;
    res_t           res;
    logic [CpW-1:0] part;
    logic [1:0]     need;
    logic [7:0]     lo;
    logic [7:0]     hi;
  } lead_t;

  logic [CpW-1:0] part_r, part_nxt;
  logic [1:0]     need_r, need_nxt;
  logic [1:0]     seen_r, seen_nxt;
  logic [7:0]     lo_r, lo_nxt;
  logic [7:0]     hi_r, hi_nxt;

  logic           fire;
  logic [CpW-1:0] err_cp;
  lead_t          ld;
  logic [CpW-1:0] shifted;
  logic [1:0]     seen_inc;
  logic           in_bounds;

  // lead byte decode from a cleared sequence state
  function automatic lead_t lead_decode(input logic [7:0] b, input logic [CpW-1:0] ecp);
    lead_t l;
    l.emit   = 1'b0;
    l.res.cp = '0;
    l.res.st = ST_VALID;
    l.part   = '0;
    l.need   = 2'd0;
    l.lo     = ContLo;
    l.hi     = ContHi;
    if (b <= AsciiMax) begin
      l.emit   = 1'b1;
      l.res.cp = {{(CpW-8){1'b0}}, b};
    end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
      l.need = 2'd1;
      l.part = {{(CpW-5){1'b0}}, b[4:0]};
    end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
      l.need = 2'd2;
      l.part = {{(CpW-4){1'b0}}, b[3:0]};
      if (b == LeadE0) l.lo = ContLoE0;
      if (b == LeadED) l.hi = ContHiED;
    end else if (b >= LeadFourLo && b <= LeadFourHi) begin
      l.need = 2'd3;
      l.part = {{(CpW-3){1'b0}}, b[2:0]};
      if (b == LeadF0) l.lo = ContLoF0;
      if (b == LeadF4) l.hi = ContHiF4;
    end else begin
      l.emit   = 1'b1;
      l.res.cp = ecp;
      l.res.st = ST_ERROR;
    end
    return l;
  endfunction

  assign byte_ready = q_ready;
  assign fire       = byte_valid && q_ready;
  assign err_cp     = replace ? ReplacementCp : '0;
  assign ld         = lead_decode(byte_in, err_cp);
  assign shifted    = {part_r[CpW-7:0], byte_in[5:0]};
  assign seen_inc   = seen_r + 2'd1;
  assign in_bounds  = (byte_in >= lo_r) && (byte_in <= hi_r);

  always_comb begin
    part_nxt  = part_r;
    need_nxt  = need_r;
    seen_nxt  = seen_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    q_push    = 1'b0;
    q_job.r0  = '{cp: err_cp, st: ST_ERROR};
    q_job.r1  = '{cp: '0, st: ST_END};
    q_job.two = 1'b0;
    if (byte_in == EndByte) begin
      q_push   = fire;
      part_nxt = '0;
      need_nxt = 2'd0;
      seen_nxt = 2'd0;
      lo_nxt   = ContLo;
      hi_nxt   = ContHi;
      if (need_r != 2'd0) begin
        q_job.two = 1'b1;
      end else begin
        q_job.r0 = '{cp: '0, st: ST_END};
      end
    end else if (need_r == 2'd0 || !in_bounds) begin
      part_nxt = ld.part;
      need_nxt = ld.need;
      seen_nxt = 2'd0;
      lo_nxt   = ld.lo;
      hi_nxt   = ld.hi;
      if (need_r == 2'd0) begin
        q_push   = fire && ld.emit;
        q_job.r0 = ld.res;
      end else begin
        // bad continuation: error, then the byte again as a lead byte
        q_push    = fire;
        q_job.r1  = ld.res;
        q_job.two = ld.emit;
      end
    end else begin
      lo_nxt   = ContLo;
      hi_nxt   = ContHi;
      part_nxt = shifted;
      seen_nxt = seen_inc;
      if (seen_inc == need_r) begin
        q_push   = fire;
        q_job.r0 = '{cp: shifted, st: ST_VALID};
        part_nxt = '0;
        need_nxt = 2'd0;
        seen_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      need_r <= 2'd0;
      seen_r <= 2'd0;
      lo_r   <= ContLo;
      hi_r   <= ContHi;
    end else if (fire) begin
      part_r <= part_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

FILE: hw/rtl/u8sd_fifo.sv
module u8sd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8sd_pkg::job_t push_job,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output u8sd_pkg::job_t pop_job
);
  import u8sd_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [PtrW:0]   cnt_r;
  logic            do_push, do_pop;

  assign not_full  = (cnt_r != Depth[PtrW:0]);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/u8sd_back.sv
module u8sd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  u8sd_pkg::job_t q_job,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output u8sd_pkg::res_t res,
  output logic           res_last
);
  import u8sd_pkg::*;

  job_t job_r;
  logic valid_r;
  logic idx_r;
  logic done;

  // current job finishes on this transfer
  assign done      = res_valid && res_ready && (idx_r || !job_r.two);
  assign q_pop     = !valid_r || done;
  assign res_valid = valid_r;
  assign res       = idx_r ? job_r.r1 : job_r.r0;
  assign res_last  = idx_r || !job_r.two;

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) job_r <= q_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (q_pop) begin
      valid_r <= q_valid;
      idx_r   <= 1'b0;
    end else if (res_ready) begin
      idx_r <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/u8sd_checker.sv
module u8sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import u8sd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  a_end_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_END |-> out_tdata == '0 && out_tlast)
    else $error("end result not zero or not last");

  a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_VALID |-> out_tdata <= 24'h10FFFF)
    else $error("code point out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: sim/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8sd_pkg::*;

  localparam int unsigned QuietLimit = 4000;

  typedef struct {
    logic [CpW-1:0] cp;
    status_t        st;
    logic           last;
  } decoded_t;

  class utf8_scoreboard;
    logic           replace_on;
    logic [CpW-1:0] partial;
    logic [1:0]     needed;
    logic [1:0]     seen;
    logic [7:0]     lo_bound;
    logic [7:0]     hi_bound;
    decoded_t       pending[$];
    int             errors;
    int             n_bytes;
    int             n_valid;
    int             n_malformed;
    int             n_end;

    function new();
      replace_on  = 1'b1;
      errors      = 0;
      n_bytes     = 0;
      n_valid     = 0;
      n_malformed = 0;
      n_end       = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      partial  = '0;
      needed   = '0;
      seen     = '0;
      lo_bound = ContLo;
      hi_bound = ContHi;
    endfunction

    function logic [CpW-1:0] error_cp();
      return replace_on ? ReplacementCp : '0;
    endfunction

    function void push(logic [CpW-1:0] cp, status_t st);
      decoded_t d;
      d.cp   = cp;
      d.st   = st;
      d.last = 1'b0;
      pending.push_back(d);
    endfunction

    function void decode_lead(logic [7:0] b);
      if (b <= AsciiMax) begin
        push(CpW'(b), ST_VALID);
      end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
        needed  = 2'd1;
        partial = CpW'(b[4:0]);
      end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
        if (b == LeadE0) lo_bound = ContLoE0;
        else if (b == LeadED) hi_bound = ContHiED;
        needed  = 2'd2;
        partial = CpW'(b[3:0]);
      end else if (b >= LeadFourLo && b <= LeadFourHi) begin
        if (b == LeadF0) lo_bound = ContLoF0;
        else if (b == LeadF4) hi_bound = ContHiF4;
        needed  = 2'd3;
        partial = CpW'(b[2:0]);
      end else begin
        push(error_cp(), ST_ERROR);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int             base;
      logic [CpW-1:0] cp;
      decoded_t       tail;
      base = pending.size();
      n_bytes++;
      if (b == EndByte) begin
        if (needed != 0) begin
          clear_seq();
          push(error_cp(), ST_ERROR);
        end
        push('0, ST_END);
      end else if (needed == 0) begin
        decode_lead(b);
      end else if (b < lo_bound || b > hi_bound) begin
        // failed continuation, then the same byte starts afresh
        clear_seq();
        push(error_cp(), ST_ERROR);
        decode_lead(b);
      end else begin
        lo_bound = ContLo;
        hi_bound = ContHi;
        partial  = {partial[CpW-7:0], b[5:0]};
        seen     = seen + 2'd1;
        if (seen == needed) begin
          cp = partial;
          clear_seq();
          push(cp, ST_VALID);
        end
      end
      if (pending.size() > base) begin
        tail      = pending.pop_back();
        tail.last = 1'b1;
        pending.push_back(tail);
      end
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [CpW-1:0] cp, status_t st, logic last);
      decoded_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result cp=%h st=%0d last=%0b", cp, st, last));
      end else begin
        e = pending.pop_front();
        case (e.st)
          ST_VALID: n_valid++;
          ST_ERROR: n_malformed++;
          default:  n_end++;
        endcase
        if (cp !== e.cp) report($sformatf("code point %h, expected %h", cp, e.cp));
        if (st !== e.st) report($sformatf("status %0d, expected %0d", st, e.st));
        if (last !== e.last) report($sformatf("tlast %0b, expected %0b", last, e.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  utf8_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned quiet;

  utf8_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.replace_on = cfg_data;
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata[CpW-1:0], status_t'(out_tuser), out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_unit(inout int sent);
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         n;
    int         kind;
    int         pos;
    kind = $urandom_range(99);
    n = 1;
    if (kind < 15) begin
      seq[0] = 8'($urandom_range(127, 1));
    end else if (kind < 20) begin
      seq[0] = EndByte;
    end else if (kind < 35) begin
      seq[0] = 8'($urandom_range(255));
    end else begin
      n = $urandom_range(4, 2);
      case (n)
        2: seq[0] = 8'($urandom_range(LeadTwoHi, LeadTwoLo));
        3: begin
          case ($urandom_range(3))
            0:       seq[0] = LeadE0;
            1:       seq[0] = LeadED;
            default: seq[0] = 8'($urandom_range(LeadThreeHi, LeadThreeLo));
          endcase
        end
        default: begin
          case ($urandom_range(3))
            0:       seq[0] = LeadF0;
            1:       seq[0] = LeadF4;
            default: seq[0] = 8'($urandom_range(LeadFourHi, LeadFourLo));
          endcase
        end
      endcase
      lo = ContLo;
      hi = ContHi;
      case (seq[0])
        LeadE0:  lo = ContLoE0;
        LeadED:  hi = ContHiED;
        LeadF0:  lo = ContLoF0;
        LeadF4:  hi = ContHiF4;
        default: ;
      endcase
      seq[1] = 8'($urandom_range(hi, lo));
      for (int i = 2; i < n; i++) seq[i] = 8'($urandom_range(ContHi, ContLo));
      // broken sequences: corrupt one continuation or cut the sequence short
      if (kind >= 88) begin
        pos = $urandom_range(n - 1, 1);
        if (kind[0]) seq[pos] = 8'($urandom_range(255));
        else n = pos;
      end
    end
    for (int i = 0; i < n; i++) send_byte(seq[i]);
    sent += n;
  endtask

  task automatic write_replace(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  int   phase_idle  [4] = '{0, 83, 0, 30};
  int   phase_stall [4] = '{0, 0, 83, 30};
  logic phase_cfg   [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
  logic [7:0] directed_bytes[$] = '{
    8'h7F, 8'h80, 8'hC1, 8'hFF,
    8'hC2, 8'h80,
    8'hE0, 8'hA0, 8'h80,
    8'hE0, 8'h9F,
    8'hED, 8'hA0,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF0, 8'h8F,
    8'hE1, 8'h41,
    8'hF3, 8'h00,
    8'h00
  };

  initial begin
    int sent;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      write_replace(phase_cfg[p]);
      if (p == 0) begin
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      end
      sent = 0;
      while (sent < 475) send_random_unit(sent);
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d bytes in four idle/stall phases, both error code point settings",
             sb.n_bytes);
    $display("results checked: %0d valid, %0d malformed, %0d end of string",
             sb.n_valid, sb.n_malformed, sb.n_end);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
